// ===== rtl/p2g_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2g_pkg
// Shared types and constants of the particle-to-grid scatter block.
// ----------------------------------------------------------------------------
package p2g_pkg;

	localparam int CELL_W  = 9;   // cell index, enough for 256 cells
	localparam int IDX_W   = 7;   // node index field of a read
	localparam int POS_W   = 16;
	localparam int VEL_W   = 24;
	localparam int DATA_W  = 32;
	localparam int WGT_W   = 16;
	localparam int DIST_W  = 18;
	localparam int NUM_W   = 56;

	localparam logic [DIST_W-1:0] ONE_Q16 = 18'd65536;
	localparam logic [DIST_W-1:0] TWO_Q16 = 18'd131072;
	localparam logic [17:0]       RECIP3  = 18'd174763;  // ceil(2^19 / 3)
	localparam logic [DATA_W-1:0] PMASS_RESET = 32'h0001_0000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_MASS  = 2'd1,
		OP_VEL   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [CELL_W-1:0]       cx;
		logic [POS_W-1:0]        fx;
		logic [CELL_W-1:0]       cy;
		logic [POS_W-1:0]        fy;
		logic signed [VEL_W-1:0] vel_x;
		logic signed [VEL_W-1:0] vel_y;
		logic [IDX_W-1:0]        node_x;
		logic [IDX_W-1:0]        node_y;
		logic                    rd_in;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_CLR,
		ST_WGT,
		ST_NODE_A,
		ST_NODE_B,
		ST_NODE_C,
		ST_DIV,
		ST_VEL_WR,
		ST_RD_A,
		ST_RD_B,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/particle_to_grid_transfer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_to_grid_transfer_top
// Particle-to-grid scatter of a material point method on a square node grid.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_valid/in_ready channel, one transfer per command
//   (clear, scatter mass, scatter velocity, read node). Every command yields
//   exactly one transfer on out_valid/out_ready: node fields for an in-grid
//   read, zeros otherwise, and the saturated flag for the two scatters.
//   The particle mass register is written through the APB port at address 0;
//   the user writes it only while idle; the block does not enforce this.
//   Steps, set by the single-port node stores:
//     clear: one node of each store per cycle.
//     scatter mass: eight spline weights, four per axis; then per node of the
//       4x4 neighborhood a read, weight and mass write if it is in the grid, or a
//       skip if it is off the grid; plus dispatch and result.
//     scatter velocity: as mass, but a divide and a velocity write in place of
//       the mass write, only for nodes with nonzero mass. read: one store read.
//   A two-entry queue takes commands while the sequencer works; a finished
//   result waits in the output register while the queue keeps filling.
//   Reset: the particle mass returns to 1.0 and a clearing pass zeroes the
//   stores; in_ready stays low until it ends.
//   A stalled receiver holds the result; the sequencer waits before the
//   next command, and the queue backs up to in_ready.
// ----------------------------------------------------------------------------
module particle_to_grid_transfer_top #(
	parameter int GRID_CELLS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [2:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        operation,
	input  wire logic [p2g_pkg::POS_W-1:0]         pos_x,
	input  wire logic [p2g_pkg::POS_W-1:0]         pos_y,
	input  wire logic signed [p2g_pkg::VEL_W-1:0]  vel_x,
	input  wire logic signed [p2g_pkg::VEL_W-1:0]  vel_y,
	input  wire logic [p2g_pkg::IDX_W-1:0]         node_x,
	input  wire logic [p2g_pkg::IDX_W-1:0]         node_y,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [p2g_pkg::DATA_W-1:0]             node_mass,
	output logic signed [p2g_pkg::DATA_W-1:0]      node_vel_x,
	output logic signed [p2g_pkg::DATA_W-1:0]      node_vel_y,
	output logic                                   saturated
);
	import p2g_pkg::*;

	localparam logic REG_PMASS = 1'b0;   // word index of the particle mass

	logic [DATA_W-1:0] pmass_q;
	logic              init_busy;
	logic              push;
	logic              pop;
	cmd_t              push_cmd;
	cmd_t              pop_cmd;
	q_stat_t           q_stat;

	// configuration: write on the access phase, pready tied high
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PMASS) ? pmass_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmass_q <= PMASS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PMASS) begin
			pmass_q <= pwdata;
		end
	end

	// front: handshake and classification
	p2g_front #(
		.GRID_CELLS (GRID_CELLS)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.node_x    (node_x),
		.node_y    (node_y),
		.init_busy (init_busy),
		.q_stat    (q_stat),
		.push      (push),
		.cmd       (push_cmd)
	);

	// decoupling queue
	p2g_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.q_stat    (q_stat)
	);

	// back: sequencer, node stores, result register
	p2g_back #(
		.GRID_CELLS (GRID_CELLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.q_cmd      (pop_cmd),
		.pop        (pop),
		.pmass      (pmass_q),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.node_mass  (node_mass),
		.node_vel_x (node_vel_x),
		.node_vel_y (node_vel_y),
		.saturated  (saturated)
	);

endmodule
`default_nettype wire

// ===== rtl/p2g_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2g_front
// Input handshake and classification: cell index, fraction, read range.
// ----------------------------------------------------------------------------
module p2g_front #(
	parameter int GRID_CELLS = 64
) (
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       operation,
	input  wire logic [p2g_pkg::POS_W-1:0]        pos_x,
	input  wire logic [p2g_pkg::POS_W-1:0]        pos_y,
	input  wire logic signed [p2g_pkg::VEL_W-1:0] vel_x,
	input  wire logic signed [p2g_pkg::VEL_W-1:0] vel_y,
	input  wire logic [p2g_pkg::IDX_W-1:0]        node_x,
	input  wire logic [p2g_pkg::IDX_W-1:0]        node_y,
	input  wire logic                             init_busy,
	input  wire p2g_pkg::q_stat_t                 q_stat,
	output logic                                  push,
	output p2g_pkg::cmd_t                         cmd
);
	import p2g_pkg::*;

	localparam int PX_W = POS_W + CELL_W;

	logic [PX_W-1:0] px;
	logic [PX_W-1:0] py;

	assign px = PX_W'(pos_x) * PX_W'(GRID_CELLS);
	assign py = PX_W'(pos_y) * PX_W'(GRID_CELLS);

	assign in_ready = !q_stat.full && !init_busy;
	assign push     = in_valid && in_ready;

	always_comb begin
		cmd.op     = op_t'(operation);
		cmd.cx     = px[PX_W-1:POS_W];
		cmd.fx     = px[POS_W-1:0];
		cmd.cy     = py[PX_W-1:POS_W];
		cmd.fy     = py[POS_W-1:0];
		cmd.vel_x  = vel_x;
		cmd.vel_y  = vel_y;
		cmd.node_x = node_x;
		cmd.node_y = node_y;
		cmd.rd_in  = (CELL_W'(node_x) <= CELL_W'(GRID_CELLS))
			&& (CELL_W'(node_y) <= CELL_W'(GRID_CELLS));
	end

endmodule
`default_nettype wire

// ===== rtl/p2g_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2g_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module p2g_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire p2g_pkg::cmd_t push_data,
	input  wire logic          pop,
	output p2g_pkg::cmd_t      pop_data,
	output p2g_pkg::q_stat_t   q_stat
);
	import p2g_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign q_stat.full  = cnt_q == 2'd2;
	assign q_stat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== rtl/p2g_weight.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2g_weight
// Five-stage cubic B-spline unit: distance in Q.16 to a rounded Q.16 weight.
// ----------------------------------------------------------------------------
module p2g_weight (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	input  wire logic [p2g_pkg::DIST_W-1:0]  span,
	input  wire logic [2:0]                  in_tag,
	output logic                             out_valid,
	output logic [2:0]                       out_tag,
	output logic [p2g_pkg::WGT_W-1:0]        weight
);
	import p2g_pkg::*;

	logic [4:0]  vld_q;
	logic [2:0]  tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic        zero_s1, zero_s2, zero_s3, zero_s4;
	logic        br_s1, br_s2, br_s3;
	logic [16:0] t_s1, t_s2;
	logic [33:0] t2_s2, t2_s3;
	logic [50:0] t3_s3;
	logic [17:0] n_s4;
	logic [WGT_W-1:0] w_s5;
	logic [DIST_W-1:0] tb;
	logic [51:0] num;
	logic [51:0] nsum;
	logic [35:0] qprod;

	assign tb = TWO_Q16 - span;

	always_comb begin
		num = br_s3 ? (52'(t3_s3) * 52'd3 + (52'd1 << 50) - ((52'(t2_s3) * 52'd6) << 16))
			: 52'(t3_s3);
		nsum  = num + (52'd3 << 32);
		qprod = 36'(n_s4) * 36'(RECIP3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// classify: inner lobe, outer lobe (2 - a), or outside support
		br_s1   <= span < ONE_Q16;
		zero_s1 <= !(span < TWO_Q16);
		t_s1    <= (span < ONE_Q16) ? span[16:0] : tb[16:0];
		tag_s1  <= in_tag;

		t2_s2   <= 34'(t_s1) * 34'(t_s1);
		t_s2    <= t_s1;
		br_s2   <= br_s1;
		zero_s2 <= zero_s1;
		tag_s2  <= tag_s1;

		t3_s3   <= 51'(t2_s2) * 51'(t_s2);
		t2_s3   <= t2_s2;
		br_s3   <= br_s2;
		zero_s3 <= zero_s2;
		tag_s3  <= tag_s2;

		// divide by 6 * 2^32 with rounding: shift by 33 here, then multiply by the reciprocal of 3
		n_s4    <= nsum[50:33];
		zero_s4 <= zero_s3;
		tag_s4  <= tag_s3;

		w_s5    <= zero_s4 ? '0 : qprod[34:19];
		tag_s5  <= tag_s4;
	end

	assign out_valid = vld_q[4];
	assign out_tag   = tag_s5;
	assign weight    = w_s5;

endmodule
`default_nettype wire

// ===== rtl/p2g_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2g_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module p2g_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [p2g_pkg::NUM_W-1:0]  numer,
	input  wire logic [p2g_pkg::DATA_W-1:0] denom,
	output logic                            busy,
	output logic [p2g_pkg::NUM_W-1:0]       quot
);
	import p2g_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DATA_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

// ===== rtl/p2g_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// p2g_back
// Sequencer that carries out commands on the node stores: clear sweep,
// 4x4 scatter by read-modify-write, node read, result register.
// ----------------------------------------------------------------------------
module p2g_back #(
	parameter int GRID_CELLS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire p2g_pkg::q_stat_t                  q_stat,
	input  wire p2g_pkg::cmd_t                     q_cmd,
	output logic                                   pop,
	input  wire logic [p2g_pkg::DATA_W-1:0]        pmass,
	output logic                                   init_busy,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [p2g_pkg::DATA_W-1:0]             node_mass,
	output logic signed [p2g_pkg::DATA_W-1:0]      node_vel_x,
	output logic signed [p2g_pkg::DATA_W-1:0]      node_vel_y,
	output logic                                   saturated
);
	import p2g_pkg::*;

	localparam int NPS        = GRID_CELLS + 1;
	localparam int NODE_COUNT = NPS * NPS;
	localparam int AW         = $clog2(NODE_COUNT);
	localparam logic [2:0] LAST_TAG = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} sat_word_t;

	// velocity contribution: clamp the signed quotient, add, clamp the sum
	function automatic sat_word_t vel_update(input logic [DATA_W-1:0] acc,
		input logic [NUM_W-1:0] q, input logic neg);
		sat_word_t         r;
		logic              over;
		logic [DATA_W:0]   mag_c;
		logic [DATA_W+1:0] c;
		logic [DATA_W+1:0] s;
		if (!neg) begin
			over  = q[NUM_W-1:DATA_W-1] != '0;
			mag_c = over ? 33'h0_7FFF_FFFF : {1'b0, q[DATA_W-1:0]};
		end else begin
			over  = (q[NUM_W-1:DATA_W] != '0) || (q[DATA_W-1] && (q[DATA_W-2:0] != '0));
			mag_c = over ? 33'h0_8000_0000 : q[DATA_W:0];
		end
		c = neg ? (DATA_W+2)'(-{1'b0, mag_c}) : {1'b0, mag_c};
		s = {{2{acc[DATA_W-1]}}, acc} + c;
		r.sat = over;
		if (s[DATA_W+1:DATA_W-1] == 3'b000 || s[DATA_W+1:DATA_W-1] == 3'b111) begin
			r.val = s[DATA_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = s[DATA_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	state_t state_q, state_d;
	cmd_t   cmd_q;

	logic [DATA_W-1:0] mass_mem [NODE_COUNT];
	logic [DATA_W-1:0] velx_mem [NODE_COUNT];
	logic [DATA_W-1:0] vely_mem [NODE_COUNT];
	logic [DATA_W-1:0] rd_mass_q, rd_velx_q, rd_vely_q;

	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    mem_addr;
	logic [3:0]       n_q;
	logic [3:0]       wiss_q;
	logic [WGT_W-1:0] wx_q [4];
	logic [WGT_W-1:0] wy_q [4];
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] wm_q;
	logic              sat_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_mass_q, out_vx_q, out_vy_q;
	logic              out_sat_q;

	logic pop_c, mem_re, we_mass, we_vel, clr_wr, wgt_issue, div_start, out_load;
	logic node_done, node_in, last_node, clr_last;

	logic [1:0]           jx, jy;
	logic signed [CELL_W:0] kx, ky;
	logic [AW-1:0]        node_addr;
	logic [AW-1:0]        read_addr;
	logic [DIST_W-1:0]    span;
	logic [POS_W-1:0]     fsel;
	logic                 wgt_vld;
	logic [2:0]           wgt_tag;
	logic [WGT_W-1:0]     wgt_w;
	logic [DATA_W:0]      wrnd;
	logic [48:0]          wmsum;
	logic [DATA_W:0]      msum;
	logic [VEL_W-1:0]     magx, magy;
	logic [NUM_W-1:0]     numx, numy, quox, quoy;
	logic                 busyx, busyy;
	sat_word_t            vxn, vyn;
	logic [DATA_W-1:0]    wd_mass, wd_vx, wd_vy;

	// ------------------------------------------------------------------
	// node geometry
	// ------------------------------------------------------------------
	assign jx = n_q[3:2];
	assign jy = n_q[1:0];
	assign kx = signed'({1'b0, cmd_q.cx} + (CELL_W+1)'(jx) - (CELL_W+1)'(1));
	assign ky = signed'({1'b0, cmd_q.cy} + (CELL_W+1)'(jy) - (CELL_W+1)'(1));
	assign node_in = !kx[CELL_W] && !ky[CELL_W]
		&& (kx[CELL_W-1:0] <= CELL_W'(GRID_CELLS))
		&& (ky[CELL_W-1:0] <= CELL_W'(GRID_CELLS));
	assign node_addr = AW'(kx[CELL_W-1:0]) * AW'(NPS) + AW'(ky[CELL_W-1:0]);
	assign read_addr = AW'(cmd_q.node_x) * AW'(NPS) + AW'(cmd_q.node_y);
	assign last_node = n_q == 4'd15;
	assign clr_last  = clr_q == AW'(NODE_COUNT - 1);

	// distances for the weight unit: 1+f, f, 1-f, 2-f per axis
	assign fsel = wiss_q[2] ? cmd_q.fy : cmd_q.fx;
	always_comb begin
		case (wiss_q[1:0])
			2'd0:    span = DIST_W'(fsel) + ONE_Q16;
			2'd1:    span = DIST_W'(fsel);
			2'd2:    span = ONE_Q16 - DIST_W'(fsel);
			default: span = TWO_Q16 - DIST_W'(fsel);
		endcase
	end

	p2g_weight u_weight (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (wgt_issue),
		.span      (span),
		.in_tag    (wiss_q[2:0]),
		.out_valid (wgt_vld),
		.out_tag   (wgt_tag),
		.weight    (wgt_w)
	);

	// ------------------------------------------------------------------
	// arithmetic
	// ------------------------------------------------------------------
	assign wrnd  = {1'b0, prod_q} + 33'd32768;
	assign wmsum = 49'(wrnd[DATA_W-1:16]) * 49'(pmass) + 49'd32768;
	assign msum  = {1'b0, rd_mass_q} + {1'b0, wm_q};
	assign magx  = cmd_q.vel_x[VEL_W-1] ? VEL_W'(-cmd_q.vel_x) : cmd_q.vel_x;
	assign magy  = cmd_q.vel_y[VEL_W-1] ? VEL_W'(-cmd_q.vel_y) : cmd_q.vel_y;
	assign numx  = NUM_W'(wm_q) * NUM_W'(magx) + NUM_W'(rd_mass_q[DATA_W-1:1]);
	assign numy  = NUM_W'(wm_q) * NUM_W'(magy) + NUM_W'(rd_mass_q[DATA_W-1:1]);

	p2g_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numx),
		.denom  (rd_mass_q),
		.busy   (busyx),
		.quot   (quox)
	);

	p2g_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (numy),
		.denom  (rd_mass_q),
		.busy   (busyy),
		.quot   (quoy)
	);

	assign vxn = vel_update(rd_velx_q, quox, cmd_q.vel_x[VEL_W-1]);
	assign vyn = vel_update(rd_vely_q, quoy, cmd_q.vel_y[VEL_W-1]);

	assign wd_mass = clr_wr ? '0 : (msum[DATA_W] ? '1 : msum[DATA_W-1:0]);
	assign wd_vx   = clr_wr ? '0 : vxn.val;
	assign wd_vy   = clr_wr ? '0 : vyn.val;

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT_CLR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (!q_stat.empty) begin
					case (q_cmd.op)
						OP_CLEAR: state_d = ST_CLR;
						OP_MASS:  state_d = ST_WGT;
						OP_VEL:   state_d = ST_WGT;
						default:  state_d = ST_RD_A;
					endcase
				end
			end
			ST_CLR:    if (clr_last) state_d = ST_DONE;
			ST_WGT:    if (wgt_vld && wgt_tag == LAST_TAG) state_d = ST_NODE_A;
			ST_NODE_A: begin
				if (node_in) state_d = ST_NODE_B;
				else if (last_node) state_d = ST_DONE;
			end
			ST_NODE_B: state_d = ST_NODE_C;
			ST_NODE_C: begin
				if (div_start) state_d = ST_DIV;
				else state_d = last_node ? ST_DONE : ST_NODE_A;
			end
			ST_DIV:    if (!busyx && !busyy) state_d = ST_VEL_WR;
			ST_VEL_WR: state_d = last_node ? ST_DONE : ST_NODE_A;
			ST_RD_A:   state_d = ST_RD_B;
			ST_RD_B:   state_d = ST_DONE;
			ST_DONE:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// control outputs
	// ------------------------------------------------------------------
	always_comb begin
		pop_c     = 1'b0;
		mem_re    = 1'b0;
		we_mass   = 1'b0;
		we_vel    = 1'b0;
		clr_wr    = 1'b0;
		wgt_issue = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		node_done = 1'b0;
		mem_addr  = addr_q;
		case (state_q)
			ST_INIT_CLR, ST_CLR: begin
				clr_wr   = 1'b1;
				we_mass  = 1'b1;
				we_vel   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: pop_c = !q_stat.empty;
			ST_WGT:  wgt_issue = !wiss_q[3];
			ST_NODE_A: begin
				mem_re    = node_in;
				mem_addr  = node_addr;
				node_done = !node_in;
			end
			ST_NODE_C: begin
				if (cmd_q.op == OP_MASS) we_mass = 1'b1;
				else div_start = rd_mass_q != '0;
				node_done = !div_start;
			end
			ST_VEL_WR: begin
				we_vel    = 1'b1;
				node_done = 1'b1;
			end
			ST_RD_A: begin
				mem_re   = cmd_q.rd_in;
				mem_addr = read_addr;
			end
			ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign pop       = pop_c;
	assign init_busy = state_q == ST_INIT_CLR;

	// ------------------------------------------------------------------
	// node stores
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (we_mass) mass_mem[mem_addr] <= wd_mass;
		if (we_vel) begin
			velx_mem[mem_addr] <= wd_vx;
			vely_mem[mem_addr] <= wd_vy;
		end
		if (mem_re) begin
			rd_mass_q <= mass_mem[mem_addr];
			rd_velx_q <= velx_mem[mem_addr];
			rd_vely_q <= vely_mem[mem_addr];
		end
	end

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT_CLR;
			clr_q       <= '0;
			n_q         <= '0;
			wiss_q      <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_wr) clr_q <= clr_last ? '0 : clr_q + AW'(1);
			if (pop_c) begin
				n_q    <= '0;
				wiss_q <= '0;
				sat_q  <= 1'b0;
			end else begin
				if (node_done) n_q <= n_q + 4'd1;
				if (wgt_issue) wiss_q <= wiss_q + 4'd1;
				if (we_mass && !clr_wr && msum[DATA_W]) sat_q <= 1'b1;
				if (we_vel && !clr_wr && (vxn.sat || vyn.sat)) sat_q <= 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pop_c) cmd_q <= q_cmd;
		if (wgt_vld) begin
			if (wgt_tag[2]) wy_q[wgt_tag[1:0]] <= wgt_w;
			else wx_q[wgt_tag[1:0]] <= wgt_w;
		end
		if (state_q == ST_NODE_A) begin
			addr_q <= node_addr;
			prod_q <= DATA_W'(wx_q[jx]) * DATA_W'(wy_q[jy]);
		end
		if (state_q == ST_NODE_B) wm_q <= wmsum[47:16];
		if (out_load) begin
			if (cmd_q.op == OP_READ && cmd_q.rd_in) begin
				out_mass_q <= rd_mass_q;
				out_vx_q   <= rd_velx_q;
				out_vy_q   <= rd_vely_q;
			end else begin
				out_mass_q <= '0;
				out_vx_q   <= '0;
				out_vy_q   <= '0;
			end
			out_sat_q <= sat_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign node_mass  = out_mass_q;
	assign node_vel_x = out_vx_q;
	assign node_vel_y = out_vy_q;
	assign saturated  = out_sat_q;

`ifndef NO_ASSERTIONS
	a_vel_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_VEL_WR) |-> ($past(state_q) == ST_DIV))
		else $error("velocity write without a finished division");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (busyx && busyy))
		else $error("dividers not busy after start");

	a_read_data: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == ST_NODE_B || state_q == ST_RD_B))
		else $error("store read not followed by its data cycle");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the particle-to-grid scatter block. A built-in
// fixed-point model of the node grid predicts every result; directed tests
// cover clears, edge positions, saturation and reads outside the grid, then
// random particle sets are scattered and read back, under random stalls but for the last frames.
// ----------------------------------------------------------------------------
module tb_top;
	import p2g_pkg::*;

	localparam int G       = 64;
	localparam int SIDE    = G + 1;
	localparam int NODES   = SIDE * SIDE;
	localparam logic [2:0] ADDR_PMASS = 3'd0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = OP_CLEAR;
	logic [15:0] pos_x = '0, pos_y = '0;
	logic signed [23:0] vel_x = '0, vel_y = '0;
	logic [6:0] node_x = '0, node_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] node_mass;
	logic signed [31:0] node_vel_x, node_vel_y;
	logic saturated;

	particle_to_grid_transfer_top #(.GRID_CELLS(G)) uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	typedef struct {
		logic [31:0] mass;
		logic [31:0] vx;
		logic [31:0] vy;
		logic        sat;
	} node_result_t;

	// Model state of the grid.
	logic [31:0]        grid_mass [NODES];
	logic signed [31:0] grid_vx   [NODES];
	logic signed [31:0] grid_vy   [NODES];
	logic [31:0]        mdl_pmass;

	node_result_t pending_results[$];
	int  n_errors = 0;
	bit  stall_on = 1'b1;   // random idling on both sides

	function automatic longint unsigned spline_weight(longint d);
		longint unsigned a, b, num, den;
		a = (d < 0) ? -d : d;
		den = 64'd6 << 32;
		if (a < 65536) begin
			num = 3 * a * a * a + (64'd4 << 48) - 6 * a * a * 65536;
			return (num + den / 2) / den;
		end
		if (a < 131072) begin
			b = 131072 - a;
			return (b * b * b + den / 2) / den;
		end
		return 0;
	endfunction

	function automatic longint vel_share(longint unsigned wm, longint v,
	                                      longint unsigned m);
		longint unsigned mag, q;
		mag = (v < 0) ? -v : v;
		q = (wm * mag + m / 2) / m;
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] acc_clamp(logic signed [31:0] acc, longint c,
	                                           ref bit sat);
		longint s;
		if (c > 64'sd2147483647) begin c = 64'sd2147483647; sat = 1; end
		if (c < -64'sd2147483648) begin c = -64'sd2147483648; sat = 1; end
		s = longint'(acc) + c;
		if (s > 64'sd2147483647) begin s = 64'sd2147483647; sat = 1; end
		if (s < -64'sd2147483648) begin s = -64'sd2147483648; sat = 1; end
		return s[31:0];
	endfunction

	function automatic bit scatter_particle(bit vel_pass, logic [15:0] px16,
	                                         logic [15:0] py16,
	                                         logic signed [23:0] v_x,
	                                         logic signed [23:0] v_y);
		bit sat;
		longint px, py, cx, cy, idx, vx, vy;
		longint unsigned wx, wy, w, wm, s;
		sat = 0;
		px = longint'(px16) * G;
		py = longint'(py16) * G;
		cx = px >>> 16;
		cy = py >>> 16;
		vx = v_x;
		vy = v_y;
		for (longint kx = cx - 1; kx <= cx + 2; kx++) begin
			if (kx < 0 || kx > G) continue;
			wx = spline_weight(px - kx * 65536);
			for (longint ky = cy - 1; ky <= cy + 2; ky++) begin
				if (ky < 0 || ky > G) continue;
				wy = spline_weight(py - ky * 65536);
				w = (wx * wy + 32768) >> 16;
				wm = (w * longint'(mdl_pmass) + 32768) >> 16;
				idx = kx * SIDE + ky;
				if (!vel_pass) begin
					s = longint'(grid_mass[idx]) + wm;
					if (s > 64'hFFFF_FFFF) begin s = 64'hFFFF_FFFF; sat = 1; end
					grid_mass[idx] = s[31:0];
				end else if (grid_mass[idx] != 0) begin
					grid_vx[idx] = acc_clamp(grid_vx[idx],
						vel_share(wm, vx, grid_mass[idx]), sat);
					grid_vy[idx] = acc_clamp(grid_vy[idx],
						vel_share(wm, vy, grid_mass[idx]), sat);
				end
			end
		end
		return sat;
	endfunction

	function automatic void grid_clear();
		foreach (grid_mass[i]) begin
			grid_mass[i] = '0;
			grid_vx[i]   = '0;
			grid_vy[i]   = '0;
		end
	endfunction

	function automatic node_result_t predict_grid_op(op_t op, logic [15:0] px,
	                                                  logic [15:0] py,
	                                                  logic signed [23:0] v_x,
	                                                  logic signed [23:0] v_y,
	                                                  logic [6:0] nx, logic [6:0] ny);
		node_result_t r;
		int idx;
		r = '{default: '0};
		case (op)
			OP_CLEAR: grid_clear();
			OP_MASS:  r.sat = scatter_particle(0, px, py, v_x, v_y);
			OP_VEL:   r.sat = scatter_particle(1, px, py, v_x, v_y);
			default: begin
				if (nx <= G && ny <= G) begin
					idx = nx * SIDE + ny;
					r.mass = grid_mass[idx];
					r.vx   = grid_vx[idx];
					r.vy   = grid_vy[idx];
				end
			end
		endcase
		return r;
	endfunction

	// Send one command; hold valid and payload until the transfer.
	// Valid stays high after the transfer so the next command can follow.
	task automatic send_cmd(op_t op, logic [15:0] px = 0, logic [15:0] py = 0,
	                        logic signed [23:0] v_x = 0, logic signed [23:0] v_y = 0,
	                        logic [6:0] nx = 0, logic [6:0] ny = 0);
		if (stall_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		operation <= op;
		pos_x <= px;
		pos_y <= py;
		vel_x <= v_x;
		vel_y <= v_y;
		node_x <= nx;
		node_y <= ny;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_results.insert(pending_results.size(),
			predict_grid_op(op, px, py, v_x, v_y, nx, ny));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// APB write while idle: setup then access cycle.
	task automatic write_pmass(logic [31:0] value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PMASS;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mdl_pmass = value;
	endtask

	task automatic read_node_rand();
		send_cmd(OP_READ, 0, 0, 0, 0, 7'($urandom_range(0, G)), 7'($urandom_range(0, G)));
	endtask

	// Receiver: random stalls, compare each transfer with the oldest expectation.
	always @(posedge clk) begin
		node_result_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer");
				n_errors++;
			end else begin
				e = pending_results.pop_front();
				if (node_mass !== e.mass) begin
					$error("node_mass exp %h got %h", e.mass, node_mass);
					n_errors++;
				end
				if (node_vel_x !== e.vx) begin
					$error("node_vel_x exp %h got %h", e.vx, node_vel_x);
					n_errors++;
				end
				if (node_vel_y !== e.vy) begin
					$error("node_vel_y exp %h got %h", e.vy, node_vel_y);
					n_errors++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, saturated);
					n_errors++;
				end
			end
		end
		out_ready <= !stall_on || ($urandom_range(0, 4) != 0);
	end

	task automatic test_directed();
		// Corners and both extremes of positions and velocities.
		send_cmd(OP_MASS, 16'h0000, 16'h0000);
		send_cmd(OP_MASS, 16'hFFFF, 16'hFFFF);
		send_cmd(OP_MASS, 16'h8000, 16'h0400);
		send_cmd(OP_VEL, 16'h0000, 16'h0000, 24'sh7FFFFF, -24'sh800000);
		send_cmd(OP_VEL, 16'hFFFF, 16'hFFFF, -24'sh800000, 24'sh7FFFFF);
		// Zero node mass: velocity pass far from earlier mass.
		send_cmd(OP_VEL, 16'h4000, 16'hC000, 24'sh010000, 24'sh020000);
		send_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_READ, 0, 0, 0, 0, 64, 64);
		send_cmd(OP_READ, 0, 0, 0, 0, 1, 1);
		// Reads outside the grid.
		send_cmd(OP_READ, 0, 0, 0, 0, 65, 0);
		send_cmd(OP_READ, 0, 0, 0, 0, 0, 127);
		send_cmd(OP_READ, 0, 0, 0, 0, 127, 127);
		send_cmd(OP_CLEAR);
		send_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
	endtask

	// Heavy particle mass drives mass and velocity clamps.
	task automatic test_saturation();
		write_pmass(32'hFFFF_FFFF);
		repeat (3) send_cmd(OP_MASS, 16'h2000, 16'h2000);
		write_pmass(32'h0000_0001);
		send_cmd(OP_VEL, 16'h2000, 16'h2000, 24'sh7FFFFF, -24'sh800000);
		write_pmass(32'hFFFF_FFFF);
		repeat (2) send_cmd(OP_VEL, 16'h2000, 16'h2000, 24'sh7FFFFF, -24'sh800000);
		for (int i = 7; i <= 10; i++) send_cmd(OP_READ, 0, 0, 0, 0, 7'(i), 7'(i));
		send_cmd(OP_CLEAR);
		write_pmass(32'h0000_0000);
		send_cmd(OP_MASS, 16'h1234, 16'h5678);
		send_cmd(OP_READ, 0, 0, 0, 0, 4, 21);
	endtask

	// Well-formed frames: clear, mass pass, velocity pass, reads; plus noise.
	task automatic test_random_frames();
		logic [15:0] px[8], py[8];
		int n;
		for (int f = 0; f < 40; f++) begin
			if (f % 10 == 0)
				write_pmass($urandom_range(0, 3) == 0 ? $urandom()
				            : $urandom_range(32'h0000_4000, 32'h0004_0000));
			if (f == 30) stall_on = 1'b0;
			n = $urandom_range(1, 8);
			send_cmd(OP_CLEAR);
			for (int i = 0; i < n; i++) begin
				px[i] = 16'($urandom());
				py[i] = 16'($urandom());
				if ($urandom_range(0, 1)) py[i] = px[i] ^ 16'h0123;
				send_cmd(OP_MASS, px[i], py[i]);
			end
			for (int i = 0; i < n; i++)
				send_cmd(OP_VEL, px[i], py[i], 24'($urandom()), 24'($urandom()));
			for (int i = 0; i < n; i++) begin
				send_cmd(OP_READ, 0, 0, 0, 0, 7'((px[i] * G) >> 16),
				         7'(((py[i] * G) >> 16) + $urandom_range(0, 1)));
				read_node_rand();
			end
			if ($urandom_range(0, 2) == 0)
				send_cmd(op_t'($urandom_range(1, 3)), 16'($urandom()), 16'($urandom()),
				         24'($urandom()), 24'($urandom()), 7'($urandom()), 7'($urandom()));
			if (f == 15) drain_results();   // let the pipeline run dry once
		end
	endtask

	initial begin
		grid_clear();
		mdl_pmass = PMASS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_saturation();
		write_pmass(PMASS_RESET);
		test_random_frames();
		drain_results();
		repeat (200) @(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#100ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/p2g_pkg.sv
rtl/p2g_front.sv
rtl/p2g_queue.sv
rtl/p2g_weight.sv
rtl/p2g_div.sv
rtl/p2g_back.sv
rtl/particle_to_grid_transfer_top.sv
dv/tb_top.sv
